// File: design/tss_pkg.sv
// Shared constants for the triangle scanline span unit.
// No dependencies; every other design file imports this package.
package tss_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COLOUR_BITS    = 24;

endpackage

// File: design/tss_req_if.sv
// Request channel of the span unit: three vertices, a row and a colour.
// Depends on tss_pkg.
interface tss_req_if
   import tss_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  first_x;
   logic signed [COORD_BITS-1:0]  first_y;
   logic signed [COORD_BITS-1:0]  second_x;
   logic signed [COORD_BITS-1:0]  second_y;
   logic signed [COORD_BITS-1:0]  third_x;
   logic signed [COORD_BITS-1:0]  third_y;
   logic signed [COORD_BITS-1:0]  row;
   logic        [COLOUR_BITS-1:0] fill_colour;

   modport source (
      output valid, first_x, first_y, second_x, second_y, third_x, third_y, row,
             fill_colour,
      input  ready
   );

   modport sink (
      input  valid, first_x, first_y, second_x, second_y, third_x, third_y, row,
             fill_colour,
      output ready
   );

endinterface

// File: design/tss_rsp_if.sv
// Response channel of the span unit: one fill span per row.
// Depends on tss_pkg.
interface tss_rsp_if
   import tss_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                          valid;
   logic                          ready;
   logic                          span_valid;
   logic signed [COORD_BITS-1:0]  span_left;
   logic signed [COORD_BITS-1:0]  span_right;
   logic signed [COORD_BITS-1:0]  span_row;
   logic        [COLOUR_BITS-1:0] span_colour;

   modport source (
      output valid, span_valid, span_left, span_right, span_row, span_colour,
      input  ready
   );

   modport sink (
      input  valid, span_valid, span_left, span_right, span_row, span_colour,
      output ready
   );

endinterface

// File: design/triangle_scanline_span_unit.sv
// Triangle scanline span unit: sort, edge set-up, multiply, divide, order.
// Depends on tss_pkg, tss_req_if and tss_rsp_if.
//
// Accepts one transaction per clock while the response side does not stall, and
// returns one span per transaction, in order. The pipeline depth is set by the
// restoring divider: both edge divisions run side by side, one
// quotient bit per pipeline stage, after an input register, a vertex sort
// stage, an edge set-up stage and a multiply stage, and before an add stage
// and the output register. All stages advance together; when the response
// side stalls with a span waiting, the whole pipeline holds and the request
// side sees ready low. Rows outside the triangle give span_valid low with a
// zero span, the row and colour still passed through.
module triangle_scanline_span_unit
   import tss_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tss_req_if.sink   req_chan,
   tss_rsp_if.source rsp_chan
);

   localparam int CB  = COORD_BITS;
   localparam int NST = CB + 6;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
   } vtx_type;

   typedef struct packed {
      vtx_type                a;
      vtx_type                b;
      vtx_type                c;
      logic signed [CB-1:0]   row;
      logic [COLOUR_BITS-1:0] colour;
   } tri_type;

   typedef struct packed {
      logic                   hit;
      logic signed [CB-1:0]   row;
      logic [COLOUR_BITS-1:0] colour;
   } side_type;

   typedef struct packed {
      logic signed [CB:0]   dx;
      logic [CB-1:0]        dr;
      logic [CB-1:0]        h;
      logic signed [CB-1:0] xs;
   } edge_type;

   typedef struct packed {
      side_type side;
      edge_type e1;
      edge_type e2;
   } setup_type;

   typedef struct packed {
      logic [CB-1:0]        rem;
      logic [CB-1:0]        low;
      logic [CB-1:0]        quo;
      logic                 neg;
      logic                 flat;
      logic [CB-1:0]        h;
      logic signed [CB-1:0] xs;
   } lane_type;

   typedef struct packed {
      side_type side;
      lane_type l1;
      lane_type l2;
   } div_type;

   typedef struct packed {
      side_type             side;
      logic signed [CB-1:0] e1;
      logic signed [CB-1:0] e2;
   } post_type;

   typedef struct packed {
      logic                   span_valid;
      logic signed [CB-1:0]   span_left;
      logic signed [CB-1:0]   span_right;
      logic signed [CB-1:0]   span_row;
      logic [COLOUR_BITS-1:0] span_colour;
   } out_type;

   logic      advance;
   logic      v_ff [NST];
   tri_type   in_ff, in_in;
   tri_type   sort_ff, sort_in;
   setup_type setup_ff, setup_in;
   div_type   div_ff [CB+1];
   div_type   div_in [CB+1];
   post_type  post_ff, post_in;
   out_type   out_ff, out_in;

   // One long division step: bring down the next numerator bit.
   function automatic lane_type div_step(input lane_type l);
      lane_type    r;
      logic [CB:0] t;
      r = l;
      t = {l.rem, l.low[CB-1]};
      r.low = {l.low[CB-2:0], 1'b0};
      if (t >= {1'b0, l.h}) begin
         r.rem = CB'(t - {1'b0, l.h});
         r.quo = {l.quo[CB-2:0], 1'b1};
      end else begin
         r.rem = t[CB-1:0];
         r.quo = {l.quo[CB-2:0], 1'b0};
      end
      return r;
   endfunction

   // Edge set-up: x step, row offset, height and start x.
   function automatic edge_type edge_setup(input vtx_type p, input vtx_type q,
                                           input logic signed [CB-1:0] r);
      edge_type e;
      logic signed [CB:0] dr_full;
      logic signed [CB:0] h_full;
      e.dx    = (CB+1)'(q.x) - (CB+1)'(p.x);
      dr_full = (CB+1)'(r) - (CB+1)'(p.y);
      h_full  = (CB+1)'(q.y) - (CB+1)'(p.y);
      e.dr    = dr_full[CB-1:0];
      e.h     = h_full[CB-1:0];
      e.xs    = p.x;
      return e;
   endfunction

   // Magnitude times row offset; the upper half seeds the remainder.
   function automatic lane_type lane_init(input edge_type e);
      lane_type       l;
      logic [CB:0]    mag;
      logic [2*CB-1:0] prod;
      mag  = e.dx[CB] ? (CB+1)'(-e.dx) : (CB+1)'(e.dx);
      prod = (2*CB)'(mag[CB-1:0]) * (2*CB)'(e.dr);
      l.rem  = prod[2*CB-1:CB];
      l.low  = prod[CB-1:0];
      l.quo  = '0;
      l.neg  = e.dx[CB];
      l.flat = (e.h == '0);
      l.h    = e.h;
      l.xs   = e.xs;
      return l;
   endfunction

   function automatic logic signed [CB-1:0] lane_end(input lane_type l);
      logic signed [CB:0] qs;
      logic signed [CB:0] sum;
      qs  = l.neg ? -(CB+1)'(l.quo) : (CB+1)'(l.quo);
      sum = (CB+1)'(l.xs) + qs;
      return l.flat ? l.xs : sum[CB-1:0];
   endfunction

   assign advance        = !v_ff[NST-1] || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign in_in.a.x    = req_chan.first_x;
   assign in_in.a.y    = req_chan.first_y;
   assign in_in.b.x    = req_chan.second_x;
   assign in_in.b.y    = req_chan.second_y;
   assign in_in.c.x    = req_chan.third_x;
   assign in_in.c.y    = req_chan.third_y;
   assign in_in.row    = req_chan.row;
   assign in_in.colour = req_chan.fill_colour;

   // Three compare-and-swap steps, swapping only on a strictly smaller y.
   always_comb begin
      vtx_type t;
      t       = in_ff.a;
      sort_in = in_ff;
      if (sort_in.b.y < sort_in.a.y) begin
         t         = sort_in.a;
         sort_in.a = sort_in.b;
         sort_in.b = t;
      end
      if (sort_in.c.y < sort_in.a.y) begin
         t         = sort_in.a;
         sort_in.a = sort_in.c;
         sort_in.c = t;
      end
      if (sort_in.c.y < sort_in.b.y) begin
         t         = sort_in.b;
         sort_in.b = sort_in.c;
         sort_in.c = t;
      end
   end

   always_comb begin
      setup_in.side.hit    = (sort_ff.row >= sort_ff.a.y) && (sort_ff.row <= sort_ff.c.y);
      setup_in.side.row    = sort_ff.row;
      setup_in.side.colour = sort_ff.colour;
      if (sort_ff.row <= sort_ff.b.y) begin
         setup_in.e1 = edge_setup(sort_ff.a, sort_ff.b, sort_ff.row);
      end else begin
         setup_in.e1 = edge_setup(sort_ff.b, sort_ff.c, sort_ff.row);
      end
      setup_in.e2 = edge_setup(sort_ff.a, sort_ff.c, sort_ff.row);
   end

   always_comb begin
      div_in[0].side = setup_ff.side;
      div_in[0].l1   = lane_init(setup_ff.e1);
      div_in[0].l2   = lane_init(setup_ff.e2);
   end

   for (genvar k = 1; k <= CB; k++) begin : g_div
      always_comb begin
         div_in[k].side = div_ff[k-1].side;
         div_in[k].l1   = div_step(div_ff[k-1].l1);
         div_in[k].l2   = div_step(div_ff[k-1].l2);
      end
   end

   always_comb begin
      post_in.side = div_ff[CB].side;
      post_in.e1   = lane_end(div_ff[CB].l1);
      post_in.e2   = lane_end(div_ff[CB].l2);
   end

   // Put the ends in order; drop them to zero off the triangle.
   always_comb begin
      out_in.span_valid  = post_ff.side.hit;
      out_in.span_row    = post_ff.side.row;
      out_in.span_colour = post_ff.side.colour;
      out_in.span_left   = '0;
      out_in.span_right  = '0;
      if (post_ff.side.hit) begin
         if (post_ff.e1 > post_ff.e2) begin
            out_in.span_left  = post_ff.e2;
            out_in.span_right = post_ff.e1;
         end else begin
            out_in.span_left  = post_ff.e1;
            out_in.span_right = post_ff.e2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v_ff[0] <= req_chan.valid;
         for (int i = 1; i < NST; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff    <= in_in;
         sort_ff  <= sort_in;
         setup_ff <= setup_in;
         for (int k = 0; k <= CB; k++) begin
            div_ff[k] <= div_in[k];
         end
         post_ff  <= post_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_chan.valid       = v_ff[NST-1];
   assign rsp_chan.span_valid  = out_ff.span_valid;
   assign rsp_chan.span_left   = out_ff.span_left;
   assign rsp_chan.span_right  = out_ff.span_right;
   assign rsp_chan.span_row    = out_ff.span_row;
   assign rsp_chan.span_colour = out_ff.span_colour;

endmodule
